// ----- design/dbm_pkg.sv -----
// Shared types, widths and register codes for the debounced button block.
package dbm_pkg;

    // Width of the wrapping tick counter and of all stored tick values.
    localparam int TIME_WIDTH = 32;
    // Width of the saturating tap counter.
    localparam int TAP_COUNT_WIDTH = 8;
    // Widths of the reported fields.
    localparam int TICK_OUT_WIDTH = 32;
    localparam int TAPS_OUT_WIDTH = 8;
    // Configuration port geometry.
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_WIDTH = 4;
    localparam int REG_INDEX_WIDTH = 2;

    localparam logic [TAP_COUNT_WIDTH-1:0] TAP_MAX = '1;

    typedef logic [TIME_WIDTH-1:0] tick_t;
    typedef logic [TAP_COUNT_WIDTH-1:0] tap_count_t;

    // Register indexes on the configuration port.
    typedef enum logic [REG_INDEX_WIDTH-1:0] {
        REG_ACTIVE_LOW     = 2'd0,
        REG_RECORD_TAPS    = 2'd1,
        REG_DEBOUNCE_TICKS = 2'd2,
        REG_MULTITAP_TICKS = 2'd3
    } reg_index_t;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic        active_low;
        logic        record_taps;
        logic [15:0] debounce_ticks;
        logic [15:0] multitap_ticks;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic                      is_pressed;
        logic                      new_tap;
        logic                      event_valid;
        logic [TAPS_OUT_WIDTH-1:0] event_taps;
        logic [TICK_OUT_WIDTH-1:0] event_start;
        logic [TICK_OUT_WIDTH-1:0] event_end;
        logic [TICK_OUT_WIDTH-1:0] held_ticks;
    } result_t;

    // Fit a tick value to the reported field width.
    function automatic logic [TICK_OUT_WIDTH-1:0] tick_out(input tick_t t);
        logic [TIME_WIDTH+TICK_OUT_WIDTH-1:0] ext;
        ext = {{TICK_OUT_WIDTH{1'b0}}, t};
        return ext[TICK_OUT_WIDTH-1:0];
    endfunction

    // Fit a tap count to the reported field width.
    function automatic logic [TAPS_OUT_WIDTH-1:0] taps_out(input tap_count_t c);
        logic [TAP_COUNT_WIDTH+TAPS_OUT_WIDTH-1:0] ext;
        ext = {{TAPS_OUT_WIDTH{1'b0}}, c};
        return ext[TAPS_OUT_WIDTH-1:0];
    endfunction

endpackage

// ----- design/debounced_button_multitap.sv -----
// Top level of the debounced push button with multi-tap event grouping.
//
// Each request on the input channel is one time tick carrying the raw pin
// level (req_valid, req_stall, pin_level). Every request produces exactly one
// result on the output channel (res_valid, res_stall and the result fields):
// the debounced state, a new-tap pulse, a finished tap event if one closed
// on that tick, and the ticks since the last accepted change.
// A request is registered at the edge it is accepted and then processed by
// the update logic; its result is loaded into the output register once that
// register is free, and res_valid rises with it. One request is taken every
// cycle as long as the output side keeps up; the loop through the state
// registers sets that rate. When the receiver raises res_stall, the result
// holds in the output register, the registered request waits, and req_stall
// rises only once both are occupied. Reset clears the tick counter, tap state
// and pipeline, puts the button in the released state and loads the register
// defaults; the block accepts requests as soon as reset is released. The user
// must write registers over the APB-style port only while no request is in
// flight; the block itself does not enforce this.
module debounced_button_multitap
    import dbm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_WIDTH-1:0]     paddr,
    input  logic [DATA_WIDTH-1:0]     pwdata,
    output logic [DATA_WIDTH-1:0]     prdata,
    output logic                      pready,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic                      pin_level,
    output logic                      res_valid,
    input  logic                      res_stall,
    output logic                      is_pressed,
    output logic                      new_tap,
    output logic                      event_valid,
    output logic [TAPS_OUT_WIDTH-1:0] event_taps,
    output logic [TICK_OUT_WIDTH-1:0] event_start,
    output logic [TICK_OUT_WIDTH-1:0] event_end,
    output logic [TICK_OUT_WIDTH-1:0] held_ticks
);

    cfg_t    cfg;
    result_t result;
    result_t res_reg;
    logic    in_valid_reg, in_valid_next;
    logic    pin_reg;
    logic    out_valid_reg, out_valid_next;
    logic    out_free;
    logic    advance;
    logic    accept;

    dbm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dbm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (advance),
        .pin    (pin_reg),
        .result (result)
    );

    // Pipeline flow control.
    always_comb
    begin
        out_free       = !out_valid_reg || !res_stall;
        advance        = in_valid_reg && out_free;
        req_stall      = in_valid_reg && !out_free;
        accept         = req_valid && !req_stall;
        in_valid_next  = accept || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && res_stall);
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pin_reg <= pin_level;
        end
        if (advance)
        begin
            res_reg <= result;
        end
    end

    assign res_valid   = out_valid_reg;
    assign is_pressed  = res_reg.is_pressed;
    assign new_tap     = res_reg.new_tap;
    assign event_valid = res_reg.event_valid;
    assign event_taps  = res_reg.event_taps;
    assign event_start = res_reg.event_start;
    assign event_end   = res_reg.event_end;
    assign held_ticks  = res_reg.held_ticks;

endmodule

// ----- design/dbm_cfg.sv -----
// Configuration register file with an APB-style access port.
module dbm_cfg
    import dbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t index;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = reg_index_t'(paddr[ADDR_WIDTH-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_ACTIVE_LOW:     cfg_next.active_low     = pwdata[0];
                REG_RECORD_TAPS:    cfg_next.record_taps    = pwdata[0];
                REG_DEBOUNCE_TICKS: cfg_next.debounce_ticks = pwdata[15:0];
                REG_MULTITAP_TICKS: cfg_next.multitap_ticks = pwdata[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Read decode.
    always_comb
    begin
        unique case (index)
            REG_ACTIVE_LOW:     prdata = {{(DATA_WIDTH-1){1'b0}}, cfg_reg.active_low};
            REG_RECORD_TAPS:    prdata = {{(DATA_WIDTH-1){1'b0}}, cfg_reg.record_taps};
            REG_DEBOUNCE_TICKS: prdata = {{(DATA_WIDTH-16){1'b0}}, cfg_reg.debounce_ticks};
            REG_MULTITAP_TICKS: prdata = {{(DATA_WIDTH-16){1'b0}}, cfg_reg.multitap_ticks};
            default:            prdata = '0;
        endcase
    end

    // Register storage with reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_low     <= 1'b1;
            cfg_reg.record_taps    <= 1'b1;
            cfg_reg.debounce_ticks <= 16'd50;
            cfg_reg.multitap_ticks <= 16'd300;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- design/dbm_core.sv -----
// Debounce and multi-tap state with the per-tick update logic.
module dbm_core
    import dbm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    step,
    input  logic    pin,
    output result_t result
);

    tick_t      tick_reg, tick_next;
    logic       stable_reg, stable_next;
    tick_t      change_reg, change_next;
    tick_t      tap_tick_reg, tap_tick_next;
    tap_count_t count_reg, count_next;
    tick_t      start_reg, start_next;

    logic       pressed_level;
    tick_t      since_change;
    tick_t      since_tap;
    logic       settled;

    // One tick of debounce and tap grouping.
    always_comb
    begin
        pressed_level = ~cfg.active_low;
        tick_next     = tick_reg + 1'b1;
        since_change  = tick_next - change_reg;
        since_tap     = tick_next - tap_tick_reg;
        settled       = since_change >= TIME_WIDTH'(cfg.debounce_ticks);

        stable_next   = stable_reg;
        change_next   = change_reg;
        tap_tick_next = tap_tick_reg;
        count_next    = count_reg;
        start_next    = start_reg;

        result             = '0;

        if (settled)
        begin
            if (pin == stable_reg)
            begin
                // Quiet line: close an open event once its timeout runs out.
                if (cfg.record_taps && count_reg != '0 &&
                    since_tap >= TIME_WIDTH'(cfg.multitap_ticks))
                begin
                    result.event_valid = 1'b1;
                    result.event_taps  = taps_out(count_reg);
                    result.event_start = tick_out(start_reg);
                    result.event_end   = tick_out(tick_next);
                    count_next         = '0;
                    start_next         = '0;
                end
            end
            else
            begin
                // Accepted change; a press counts as a tap.
                if (pin == pressed_level)
                begin
                    if (cfg.record_taps)
                    begin
                        if (count_reg == '0)
                        begin
                            start_next = tick_next;
                        end
                        if (count_reg != TAP_MAX)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        tap_tick_next = tick_next;
                    end
                    result.new_tap = 1'b1;
                end
                stable_next = pin;
                change_next = tick_next;
            end
        end

        result.is_pressed = (stable_next == pressed_level);
        result.held_ticks = tick_out(tick_next - change_next);
    end

    // State registers advance once per processed tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            stable_reg   <= 1'b1;
            change_reg   <= '0;
            tap_tick_reg <= '0;
            count_reg    <= '0;
            start_reg    <= '0;
        end
        else if (step)
        begin
            tick_reg     <= tick_next;
            stable_reg   <= stable_next;
            change_reg   <= change_next;
            tap_tick_reg <= tap_tick_next;
            count_reg    <= count_next;
            start_reg    <= start_next;
        end
    end

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the debounced push button with multi-tap grouping.
module tb;
    import dbm_pkg::*;

    localparam int HOLD_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    // One line of the directed table: a tick with its pin level, or a register write.
    typedef struct packed {
        row_kind_t             kind;
        logic                  pin;
        reg_index_t            idx;
        logic [DATA_WIDTH-1:0] value;
        logic                  typed;
        result_t               want;
    } row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_WIDTH-1:0]     paddr;
    logic [DATA_WIDTH-1:0]     pwdata;
    logic [DATA_WIDTH-1:0]     prdata;
    logic                      pready;
    logic                      req_valid;
    logic                      req_stall;
    logic                      pin_level;
    logic                      res_valid;
    logic                      res_stall;
    logic                      is_pressed;
    logic                      new_tap;
    logic                      event_valid;
    logic [TAPS_OUT_WIDTH-1:0] event_taps;
    logic [TICK_OUT_WIDTH-1:0] event_start;
    logic [TICK_OUT_WIDTH-1:0] event_end;
    logic [TICK_OUT_WIDTH-1:0] held_ticks;

    // Button state as the block should hold it.
    tick_t      now_tick;
    tick_t      change_at;
    tick_t      last_tap_at;
    tick_t      event_first;
    tap_count_t taps_open;
    logic       level_held;
    logic       cfg_active_low;
    logic       cfg_record;
    logic [15:0] cfg_debounce;
    logic [15:0] cfg_window;

    // Results the block still owes, oldest first.
    result_t due_results[$];
    row_t    stim_table[$];

    int send_idle_pct;
    int recv_idle_pct;
    int ticks_sent;
    int results_seen;
    int events_seen;
    int saturated_seen;
    int taps_seen;
    int cfg_writes;
    int mismatches;
    int pressure_at;
    int pause_at;
    logic hold_ask;
    logic hold_seen;
    int hold_left;

    debounced_button_multitap dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .pin_level  (pin_level),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .is_pressed (is_pressed),
        .new_tap    (new_tap),
        .event_valid(event_valid),
        .event_taps (event_taps),
        .event_start(event_start),
        .event_end  (event_end),
        .held_ticks (held_ticks)
    );

    always #10 clk = ~clk;

    // Advance the button by one tick and return the result that tick must produce.
    function automatic result_t debounce_tick(input logic pin);
        result_t r;
        logic    pressed_lvl;
        r = '0;
        pressed_lvl = ~cfg_active_low;
        now_tick = now_tick + 1'b1;
        if (tick_t'(now_tick - change_at) >= tick_t'(cfg_debounce))
        begin
            if (pin == level_held)
            begin
                // A quiet pin closes an open event once the tap window has run out.
                if (cfg_record && taps_open != '0 &&
                    tick_t'(now_tick - last_tap_at) >= tick_t'(cfg_window))
                begin
                    r.event_valid = 1'b1;
                    r.event_taps  = taps_open;
                    r.event_start = event_first;
                    r.event_end   = now_tick;
                    taps_open     = '0;
                    event_first   = '0;
                end
            end
            else
            begin
                if (pin == pressed_lvl)
                begin
                    if (cfg_record)
                    begin
                        if (taps_open == '0)
                            event_first = now_tick;
                        if (taps_open != TAP_MAX)
                            taps_open = taps_open + 1'b1;
                        last_tap_at = now_tick;
                    end
                    r.new_tap = 1'b1;
                end
                level_held = pin;
                change_at  = now_tick;
            end
        end
        r.is_pressed = (level_held == pressed_lvl);
        r.held_ticks = now_tick - change_at;
        return r;
    endfunction

    function automatic row_t tick_row(input logic pin);
        row_t row;
        row = '0;
        row.kind = ROW_TICK;
        row.pin  = pin;
        return row;
    endfunction

    function automatic row_t tick_row_known(input logic pin, input result_t want);
        row_t row;
        row = tick_row(pin);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic row_t cfg_row(input reg_index_t idx, input logic [DATA_WIDTH-1:0] value);
        row_t row;
        row = '0;
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.value = value;
        return row;
    endfunction

    // Append one line to the directed table.
    function automatic void add_row(input row_t row);
        stim_table = {stim_table, row};
    endfunction

    // Offer one tick request, wait for it to be taken and record what it must produce.
    task automatic send_tick(input logic pin, input logic typed, input result_t want);
        result_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        pin_level <= pin;
        do @(posedge clk); while (req_stall);
        r = debounce_tick(pin);
        if (typed)
            r = want;
        due_results = {due_results, r};
        ticks_sent++;
    endtask

    // Stop offering requests and wait until every owed result has been taken.
    task automatic settle();
        req_valid <= 1'b0;
        do @(posedge clk); while (due_results.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic cfg_write(input reg_index_t idx, input logic [DATA_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ACTIVE_LOW:     cfg_active_low = value[0];
            REG_RECORD_TAPS:    cfg_record = value[0];
            REG_DEBOUNCE_TICKS: cfg_debounce = value[15:0];
            REG_MULTITAP_TICKS: cfg_window = value[15:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Button-like pin activity: alternating runs, short ones act as bounce.
    task automatic run_segment(input int n_ticks);
        logic lvl;
        int   run;
        int   span_d;
        int   span_w;
        int   k;
        span_d = (cfg_debounce > 16'd12) ? 12 : int'(cfg_debounce);
        span_w = (cfg_window > 16'd40) ? 40 : int'(cfg_window);
        lvl = 1'($urandom_range(0, 1));
        k = 0;
        while (k < n_ticks)
        begin
            lvl = ~lvl;
            if ($urandom_range(0, 9) < 6)
                run = $urandom_range(1, span_d + 2);
            else
                run = $urandom_range(1, span_w + span_d + 4);
            while (run > 0 && k < n_ticks)
            begin
                send_tick(lvl, 1'b0, '0);
                k++;
                run--;
                // Long receiver hold while requests keep coming.
                if (ticks_sent == pressure_at)
                    hold_ask <= ~hold_ask;
                // Sender pause until the block has delivered everything.
                if (ticks_sent == pause_at)
                begin
                    req_valid <= 1'b0;
                    do @(posedge clk); while (due_results.size() != 0);
                end
            end
        end
    endtask

    // Result side: random stalls, the long hold, and the comparison.
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                got.is_pressed  = is_pressed;
                got.new_tap     = new_tap;
                got.event_valid = event_valid;
                got.event_taps  = event_taps;
                got.event_start = event_start;
                got.event_end   = event_end;
                got.held_ticks  = held_ticks;
                results_seen++;
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR: result with nothing owed: pressed=%0d tap=%0d ev=%0d",
                                 got.is_pressed, got.new_tap, got.event_valid);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("ERROR: result %0d mismatch", results_seen);
                            $display("  want prs=%0d tap=%0d ev=%0d n=%0d st=%0d end=%0d held=%0d",
                                     want.is_pressed, want.new_tap, want.event_valid,
                                     want.event_taps, want.event_start, want.event_end,
                                     want.held_ticks);
                            $display("  got  prs=%0d tap=%0d ev=%0d n=%0d st=%0d end=%0d held=%0d",
                                     got.is_pressed, got.new_tap, got.event_valid,
                                     got.event_taps, got.event_start, got.event_end,
                                     got.held_ticks);
                        end
                    end
                    else if (got.event_valid)
                    begin
                        events_seen++;
                        taps_seen += int'(got.event_taps);
                        if (got.event_taps == TAP_MAX)
                            saturated_seen++;
                    end
                end
            end
            if (hold_ask != hold_seen)
            begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
        else
        begin
            // Receiver is ready and no hold is pending while reset is held.
            res_stall <= 1'b0;
            hold_seen = hold_ask;
            hold_left = 0;
        end
    end

    // Stimulus and end of run.
    initial
    begin : stimulus
        row_t row;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        req_valid = 1'b0;
        pin_level = 1'b1;
        hold_ask  = 1'b0;
        send_idle_pct = 9;
        recv_idle_pct = 66;
        ticks_sent = 0;
        results_seen = 0;
        events_seen = 0;
        saturated_seen = 0;
        taps_seen = 0;
        cfg_writes = 0;
        mismatches = 0;
        pressure_at = -1;
        pause_at = -1;

        // Register defaults and the released state after reset.
        cfg_active_low = 1'b1;
        cfg_record     = 1'b1;
        cfg_debounce   = 16'd50;
        cfg_window     = 16'd300;
        now_tick    = '0;
        change_at   = '0;
        last_tap_at = '0;
        event_first = '0;
        taps_open   = '0;
        level_held  = 1'b1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: reset state, each register, the special cases.
        // Right after reset the default debounce interval ignores the pin.
        add_row(tick_row_known(1'b0, '{1'b0, 1'b0, 1'b0, 8'd0, 32'd0, 32'd0, 32'd1}));
        add_row(tick_row_known(1'b1, '{1'b0, 1'b0, 1'b0, 8'd0, 32'd0, 32'd0, 32'd2}));
        add_row(tick_row_known(1'b0, '{1'b0, 1'b0, 1'b0, 8'd0, 32'd0, 32'd0, 32'd3}));
        add_row(cfg_row(REG_DEBOUNCE_TICKS, 32'd0));
        add_row(cfg_row(REG_MULTITAP_TICKS, 32'd0));
        // With no debounce a low pin is a press at once.
        add_row(tick_row_known(1'b0, '{1'b1, 1'b1, 1'b0, 8'd0, 32'd0, 32'd0, 32'd0}));
        add_row(tick_row(1'b1));
        add_row(tick_row(1'b1));
        // Double tap closed by a short window.
        add_row(cfg_row(REG_MULTITAP_TICKS, 32'd3));
        add_row(tick_row(1'b0));
        add_row(tick_row(1'b1));
        add_row(tick_row(1'b0));
        add_row(tick_row(1'b1));
        add_row(tick_row(1'b1));
        add_row(tick_row(1'b1));
        // An event left open while recording is off, closed once it is back on.
        add_row(tick_row(1'b0));
        add_row(cfg_row(REG_RECORD_TAPS, 32'd0));
        add_row(tick_row(1'b1));
        add_row(tick_row(1'b1));
        add_row(tick_row(1'b1));
        add_row(tick_row(1'b0));
        add_row(tick_row(1'b1));
        add_row(cfg_row(REG_RECORD_TAPS, 32'd1));
        add_row(tick_row(1'b1));
        // Polarity flip reinterprets the held level.
        add_row(cfg_row(REG_ACTIVE_LOW, 32'd0));
        add_row(tick_row(1'b1));
        add_row(tick_row(1'b0));
        add_row(tick_row(1'b1));
        // Longest debounce: the pin is ignored.
        add_row(cfg_row(REG_DEBOUNCE_TICKS, 32'd65535));
        add_row(tick_row(1'b0));
        add_row(tick_row(1'b1));
        // Longest tap window keeps the event open.
        add_row(cfg_row(REG_MULTITAP_TICKS, 32'd65535));
        add_row(cfg_row(REG_DEBOUNCE_TICKS, 32'd0));
        add_row(tick_row(1'b0));
        add_row(tick_row(1'b1));
        add_row(tick_row(1'b1));

        foreach (stim_table[i])
        begin
            row = stim_table[i];
            if (row.kind == ROW_CFG)
            begin
                settle();
                cfg_write(row.idx, row.value);
            end
            else
                send_tick(row.pin, row.typed, row.want);
        end

        // Fast tapping until the tap count saturates, then let the event close.
        settle();
        cfg_write(REG_ACTIVE_LOW, 32'd1);
        cfg_write(REG_MULTITAP_TICKS, 32'd4);
        for (int i = 0; i < 520; i++)
            send_tick(1'(i % 2), 1'b0, '0);
        for (int i = 0; i < 8; i++)
            send_tick(1'b1, 1'b0, '0);

        // Random button activity under three idling patterns.
        for (int mode = 0; mode < 3; mode++)
        begin
            if (mode == 0)
            begin
                send_idle_pct = 9;
                recv_idle_pct = 66;
            end
            else if (mode == 1)
            begin
                send_idle_pct = 66;
                recv_idle_pct = 9;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                pressure_at = ticks_sent + 20;
                pause_at = ticks_sent + 45;
            end
            for (int seg = 0; seg < 5; seg++)
            begin
                settle();
                cfg_write(REG_ACTIVE_LOW, 32'($urandom_range(0, 1)));
                cfg_write(REG_RECORD_TAPS, 32'($urandom_range(0, 3) != 0));
                if ($urandom_range(0, 19) == 0)
                    cfg_write(REG_DEBOUNCE_TICKS, 32'($urandom_range(0, 65535)));
                else
                    cfg_write(REG_DEBOUNCE_TICKS, 32'($urandom_range(0, 6)));
                if ($urandom_range(0, 19) == 0)
                    cfg_write(REG_MULTITAP_TICKS, 32'd65535);
                else
                    cfg_write(REG_MULTITAP_TICKS, 32'($urandom_range(0, 30)));
                run_segment(13);
            end
        end

        // Drain and finish.
        req_valid <= 1'b0;
        do @(posedge clk); while (due_results.size() != 0);
        repeat (6) @(posedge clk);
        $display("Sent %0d ticks over %0d register writes; %0d results checked.",
                 ticks_sent, cfg_writes, results_seen);
        $display("Saw %0d tap events holding %0d taps, %0d of them at the saturated count.",
                 events_seen, taps_seen, saturated_seen);
        if (mismatches == 0 && due_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Run limit, far above the slowest legal run.
    initial
    begin
        #4000000;
        $display("ERROR: run limit reached with %0d results owed", due_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
design/dbm_pkg.sv
design/dbm_cfg.sv
design/dbm_core.sv
design/debounced_button_multitap.sv
test/tb.sv
